// ===== hdl/blg_pkg.sv =====
package blg_pkg;

    localparam int SAMPLE_BITS    = 12;
    localparam int SUM_BITS       = 16;
    localparam int COUNT_BITS     = 4;
    localparam int AVG_COUNT      = 10;
    localparam int AVG_SHIFT      = 3;
    localparam int LEVEL_BITS     = 3;
    localparam int TARGET_BITS    = 16;
    localparam int SUPPLY_BITS    = 4;
    localparam int FULL_BITS      = 8;
    localparam int CFG_INDEX_BITS = 4;

    localparam int SUPPLY_ON_LIMIT  = 10;
    localparam int SUPPLY_OFF_LIMIT = 3;
    localparam int SUPPLY_HOLD      = 12;
    localparam int FULL_TICKS       = 150;

    localparam logic [SUM_BITS-1:0] CHG_TH4 = SUM_BITS'(1960);
    localparam logic [SUM_BITS-1:0] CHG_TH3 = SUM_BITS'(1900);
    localparam logic [SUM_BITS-1:0] CHG_TH2 = SUM_BITS'(1840);
    localparam logic [SUM_BITS-1:0] DIS_TH5 = SUM_BITS'(1968);
    localparam logic [SUM_BITS-1:0] DIS_TH4 = SUM_BITS'(1920);
    localparam logic [SUM_BITS-1:0] DIS_TH3 = SUM_BITS'(1850);
    localparam logic [SUM_BITS-1:0] DIS_TH2 = SUM_BITS'(1760);

    localparam logic [TARGET_BITS-1:0] STARTUP_TARGET_RST     = TARGET_BITS'(1);
    localparam logic [TARGET_BITS-1:0] TEST_TARGET_RST        = TARGET_BITS'(20);
    localparam logic [TARGET_BITS-1:0] NORMAL_UP_TARGET_RST   = TARGET_BITS'(30000);
    localparam logic [TARGET_BITS-1:0] NORMAL_DOWN_TARGET_RST = TARGET_BITS'(6000);

    localparam logic [1:0] PHASE_STARTUP = 2'd0;
    localparam logic [1:0] PHASE_TEST    = 2'd1;
    localparam logic [1:0] PHASE_NORMAL  = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_STARTUP_TARGET     = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TEST_TARGET        = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NORMAL_UP_TARGET   = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NORMAL_DOWN_TARGET = CFG_INDEX_BITS'(3);

    localparam logic [LEVEL_BITS-1:0] LEVEL_1 = LEVEL_BITS'(1);
    localparam logic [LEVEL_BITS-1:0] LEVEL_2 = LEVEL_BITS'(2);
    localparam logic [LEVEL_BITS-1:0] LEVEL_3 = LEVEL_BITS'(3);
    localparam logic [LEVEL_BITS-1:0] LEVEL_4 = LEVEL_BITS'(4);
    localparam logic [LEVEL_BITS-1:0] LEVEL_5 = LEVEL_BITS'(5);

    typedef logic [LEVEL_BITS-1:0] t_level;

    typedef struct packed {
        logic                   tick;
        logic [SAMPLE_BITS-1:0] adc_sample;
        logic                   supply_present;
        logic                   charge_done_pin;
        logic                   key_released;
        logic [1:0]             phase;
    } t_in_item;

    typedef struct packed {
        t_level                 battery_level;
        t_level                 raw_level;
        logic                   charger_on;
        logic                   charge_full;
        logic [SAMPLE_BITS-1:0] average_voltage;
        logic                   average_updated;
    } t_out_item;

    typedef struct packed {
        logic [TARGET_BITS-1:0] startup;
        logic [TARGET_BITS-1:0] test;
        logic [TARGET_BITS-1:0] normal_up;
        logic [TARGET_BITS-1:0] normal_down;
    } t_targets;

    typedef struct packed {
        logic charger_on;
        logic charge_full;
    } t_chg_status;

endpackage

// ===== hdl/blg_ifs.sv =====
interface blg_in_if;
    logic               valid;
    logic               ready;
    blg_pkg::t_in_item  data;

    modport src (output valid, output data, input ready);
    modport snk (input valid, input data, output ready);
endinterface

interface blg_out_if;
    logic               valid;
    logic               ready;
    blg_pkg::t_out_item data;

    modport src (output valid, output data, input ready);
    modport snk (input valid, input data, output ready);
endinterface

interface blg_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [blg_pkg::CFG_INDEX_BITS-1:0]  index;
    logic [blg_pkg::TARGET_BITS-1:0]     data;

    modport src (output valid, output index, output data, input ready);
    modport snk (input valid, input index, input data, output ready);
endinterface

// ===== hdl/battery_level_gauge.sv =====
// A transaction in the input register drains when the result register is free; all gauge
// state updates and its result is registered as it drains. Throughput: one transaction
// per cycle while the output is not stalled; the two registers hold the two sides apart.
// Reset (i_rst_n, synchronous, active low) empties both registers, restores the
// default step targets and returns the gauge to level 1, not charging.
module battery_level_gauge (
    input  logic          i_clk,
    input  logic          i_rst_n,
    blg_in_if.snk         i_in,
    blg_out_if.src        o_out,
    blg_cfg_if.snk        i_cfg
);

    logic                            r_in_valid;
    blg_pkg::t_in_item               r_in_item;
    logic                            r_out_valid;
    blg_pkg::t_out_item              r_out_item;
    blg_pkg::t_out_item              n_out_item;
    blg_pkg::t_targets               r_targets;
    logic                            advance;
    logic [blg_pkg::SAMPLE_BITS-1:0] average;
    logic                            updated;
    blg_pkg::t_chg_status            status;
    logic                            full_prev;
    blg_pkg::t_level                 level;
    blg_pkg::t_level                 raw;

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_targets.startup     <= blg_pkg::STARTUP_TARGET_RST;
            r_targets.test        <= blg_pkg::TEST_TARGET_RST;
            r_targets.normal_up   <= blg_pkg::NORMAL_UP_TARGET_RST;
            r_targets.normal_down <= blg_pkg::NORMAL_DOWN_TARGET_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                blg_pkg::CFG_STARTUP_TARGET:     r_targets.startup     <= i_cfg.data;
                blg_pkg::CFG_TEST_TARGET:        r_targets.test        <= i_cfg.data;
                blg_pkg::CFG_NORMAL_UP_TARGET:   r_targets.normal_up   <= i_cfg.data;
                blg_pkg::CFG_NORMAL_DOWN_TARGET: r_targets.normal_down <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.data;
        end
    end

    blg_avg u_avg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (advance),
        .i_sample  (r_in_item.adc_sample),
        .o_average (average),
        .o_updated (updated)
    );

    blg_charge u_charge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_tick      (r_in_item.tick),
        .i_supply    (r_in_item.supply_present),
        .i_done_pin  (r_in_item.charge_done_pin),
        .o_status    (status),
        .o_full_prev (full_prev)
    );

    blg_level u_level (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_tick      (r_in_item.tick),
        .i_key_up    (r_in_item.key_released),
        .i_phase     (r_in_item.phase),
        .i_targets   (r_targets),
        .i_status    (status),
        .i_full_prev (full_prev),
        .i_average   (average),
        .o_level     (level),
        .o_raw       (raw)
    );

    always_comb begin
        n_out_item.battery_level   = level;
        n_out_item.raw_level       = raw;
        n_out_item.charger_on      = status.charger_on;
        n_out_item.charge_full     = status.charge_full;
        n_out_item.average_voltage = average;
        n_out_item.average_updated = updated;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_item.battery_level >= blg_pkg::LEVEL_1 &&
                         r_out_item.battery_level <= blg_pkg::LEVEL_5))
        else $error("shown level out of range");

    a_full_needs_charger: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.charge_full) |-> r_out_item.charger_on)
        else $error("charge full without charger");

    a_full_forces_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.charge_full) |->
            (r_out_item.battery_level != blg_pkg::LEVEL_4))
        else $error("charge full did not pin level to top");

    a_held_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_item)))
        else $error("pending input lost while result stalled");

endmodule

// ===== hdl/blg_avg.sv =====
module blg_avg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic [blg_pkg::SAMPLE_BITS-1:0] i_sample,
    output logic [blg_pkg::SAMPLE_BITS-1:0] o_average,
    output logic                            o_updated
);

    logic [blg_pkg::SUM_BITS-1:0]    r_sum, n_sum;
    logic [blg_pkg::SAMPLE_BITS-1:0] r_max, n_max;
    logic [blg_pkg::SAMPLE_BITS-1:0] r_min, n_min;
    logic [blg_pkg::COUNT_BITS-1:0]  r_count, n_count;
    logic [blg_pkg::SAMPLE_BITS-1:0] r_average, n_average;
    logic [blg_pkg::SUM_BITS-1:0]    trimmed;

    always_comb begin
        n_max     = (i_sample >= r_max) ? i_sample : r_max;
        n_min     = (i_sample <= r_min) ? i_sample : r_min;
        n_sum     = r_sum + blg_pkg::SUM_BITS'(i_sample);
        n_count   = r_count + 1'b1;
        n_average = r_average;
        o_updated = 1'b0;
        trimmed   = n_sum - blg_pkg::SUM_BITS'(n_max) - blg_pkg::SUM_BITS'(n_min);
        if (n_count >= blg_pkg::COUNT_BITS'(blg_pkg::AVG_COUNT)) begin
            n_average = blg_pkg::SAMPLE_BITS'(trimmed >> blg_pkg::AVG_SHIFT);
            n_max     = '0;
            n_min     = '1;
            n_sum     = '0;
            n_count   = '0;
            o_updated = 1'b1;
        end
    end

    assign o_average = n_average;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_max     <= '0;
            r_min     <= '1;
            r_count   <= '0;
            r_average <= '0;
        end else if (i_en) begin
            r_sum     <= n_sum;
            r_max     <= n_max;
            r_min     <= n_min;
            r_count   <= n_count;
            r_average <= n_average;
        end
    end

endmodule

// ===== hdl/blg_charge.sv =====
module blg_charge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_tick,
    input  logic                 i_supply,
    input  logic                 i_done_pin,
    output blg_pkg::t_chg_status o_status,
    output logic                 o_full_prev
);

    logic [blg_pkg::SUPPLY_BITS-1:0] r_on, n_on;
    logic [blg_pkg::SUPPLY_BITS-1:0] r_off, n_off;
    logic [blg_pkg::FULL_BITS-1:0]   r_full, n_full;
    logic [blg_pkg::FULL_BITS-1:0]   r_nfull, n_nfull;
    blg_pkg::t_chg_status            r_status, n_status;

    always_comb begin
        n_on     = r_on + blg_pkg::SUPPLY_BITS'(i_tick);
        n_off    = r_off + blg_pkg::SUPPLY_BITS'(i_tick);
        n_full   = r_full + blg_pkg::FULL_BITS'(i_tick);
        n_nfull  = r_nfull + blg_pkg::FULL_BITS'(i_tick);
        n_status = r_status;

        if (!i_supply) begin
            n_on = '0;
        end else begin
            n_off = '0;
        end
        if (n_on > blg_pkg::SUPPLY_BITS'(blg_pkg::SUPPLY_ON_LIMIT)) begin
            n_on                = blg_pkg::SUPPLY_BITS'(blg_pkg::SUPPLY_HOLD);
            n_status.charger_on = 1'b1;
            n_nfull             = '0;
        end
        if (n_off > blg_pkg::SUPPLY_BITS'(blg_pkg::SUPPLY_OFF_LIMIT)) begin
            n_off               = blg_pkg::SUPPLY_BITS'(blg_pkg::SUPPLY_HOLD);
            n_status.charger_on = 1'b0;
            n_full              = '0;
        end

        if (n_status.charger_on) begin
            if (!i_done_pin) begin
                n_nfull = '0;
            end else begin
                n_full = '0;
            end
            if (n_full >= blg_pkg::FULL_BITS'(blg_pkg::FULL_TICKS)) begin
                n_full               = blg_pkg::FULL_BITS'(blg_pkg::FULL_TICKS);
                n_status.charge_full = 1'b1;
            end
            if (n_nfull >= blg_pkg::FULL_BITS'(blg_pkg::FULL_TICKS)) begin
                n_nfull              = blg_pkg::FULL_BITS'(blg_pkg::FULL_TICKS);
                n_status.charge_full = 1'b0;
            end
        end else begin
            n_full               = '0;
            n_nfull              = blg_pkg::FULL_BITS'(blg_pkg::FULL_TICKS);
            n_status.charge_full = 1'b0;
        end
    end

    assign o_status    = n_status;
    assign o_full_prev = r_status.charge_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on     <= '0;
            r_off    <= '0;
            r_full   <= '0;
            r_nfull  <= '0;
            r_status <= '0;
        end else if (i_en) begin
            r_on     <= n_on;
            r_off    <= n_off;
            r_full   <= n_full;
            r_nfull  <= n_nfull;
            r_status <= n_status;
        end
    end

endmodule

// ===== hdl/blg_level.sv =====
module blg_level (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_tick,
    input  logic                            i_key_up,
    input  logic [1:0]                      i_phase,
    input  blg_pkg::t_targets               i_targets,
    input  blg_pkg::t_chg_status            i_status,
    input  logic                            i_full_prev,
    input  logic [blg_pkg::SAMPLE_BITS-1:0] i_average,
    output blg_pkg::t_level                 o_level,
    output blg_pkg::t_level                 o_raw
);

    logic [blg_pkg::TARGET_BITS-1:0] r_rise, n_rise;
    logic [blg_pkg::TARGET_BITS-1:0] r_fall, n_fall;
    blg_pkg::t_level                 r_level, n_level;
    blg_pkg::t_level                 raw;
    logic [blg_pkg::TARGET_BITS-1:0] up_t, down_t;
    logic [blg_pkg::SUM_BITS-1:0]    avg;

    always_comb begin
        if (i_phase == blg_pkg::PHASE_STARTUP) begin
            up_t   = i_targets.startup;
            down_t = i_targets.startup;
        end else if (i_phase == blg_pkg::PHASE_TEST) begin
            up_t   = i_targets.test;
            down_t = i_targets.test;
        end else begin
            up_t   = i_targets.normal_up;
            down_t = i_targets.normal_down;
        end
    end

    always_comb begin
        avg = blg_pkg::SUM_BITS'(i_average);
        if (i_status.charger_on) begin
            if (i_full_prev)                  raw = blg_pkg::LEVEL_5;
            else if (avg >= blg_pkg::CHG_TH4) raw = blg_pkg::LEVEL_4;
            else if (avg >= blg_pkg::CHG_TH3) raw = blg_pkg::LEVEL_3;
            else if (avg >= blg_pkg::CHG_TH2) raw = blg_pkg::LEVEL_2;
            else                              raw = blg_pkg::LEVEL_1;
        end else begin
            if (avg >= blg_pkg::DIS_TH5)      raw = blg_pkg::LEVEL_5;
            else if (avg >= blg_pkg::DIS_TH4) raw = blg_pkg::LEVEL_4;
            else if (avg >= blg_pkg::DIS_TH3) raw = blg_pkg::LEVEL_3;
            else if (avg >= blg_pkg::DIS_TH2) raw = blg_pkg::LEVEL_2;
            else                              raw = blg_pkg::LEVEL_1;
        end
    end

    always_comb begin
        n_rise  = r_rise + blg_pkg::TARGET_BITS'(i_tick);
        n_fall  = r_fall + blg_pkg::TARGET_BITS'(i_tick & i_key_up);
        n_level = r_level;

        if (i_status.charger_on && (i_phase >= blg_pkg::PHASE_NORMAL)) begin
            // rise only while charging in normal run
            if (raw > r_level) begin
                if (n_rise > up_t) begin
                    n_rise = '0;
                    if (r_level < blg_pkg::LEVEL_5) n_level = r_level + 1'b1;
                end
            end else begin
                n_rise = '0;
            end
        end else if (raw < r_level) begin
            if (n_fall > down_t) begin
                n_fall = '0;
                if (r_level > blg_pkg::LEVEL_1) n_level = r_level - 1'b1;
            end
        end else if (raw > r_level) begin
            if (n_rise > up_t) begin
                n_rise = '0;
                if (r_level < blg_pkg::LEVEL_5) n_level = r_level + 1'b1;
            end
        end else begin
            n_fall = '0;
            n_rise = '0;
        end

        if (i_status.charger_on && i_status.charge_full &&
            (n_level == blg_pkg::LEVEL_4 || n_level == blg_pkg::LEVEL_5)) begin
            n_level = blg_pkg::LEVEL_5;
        end
    end

    assign o_level = n_level;
    assign o_raw   = raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise  <= '0;
            r_fall  <= '0;
            r_level <= blg_pkg::LEVEL_1;
        end else if (i_en) begin
            r_rise  <= n_rise;
            r_fall  <= n_fall;
            r_level <= n_level;
        end
    end

endmodule

// ===== bench/testbench.sv =====
module testbench;
    import blg_pkg::*;

    localparam int          RANDOM_ITEMS    = 625;
    localparam int          WATCHDOG_LIMIT  = 400;
    localparam int          SETTLE_CYCLES   = 3;
    localparam int          MAX_REPORTS     = 60;
    localparam logic [1:0]  PHASE_NORMAL_ALT = 2'd3;

    localparam t_out_item AT_REST = t_out_item'{LEVEL_1, LEVEL_1, 1'b0, 1'b0, 12'd0, 1'b0};
    localparam t_out_item FIRST_AVG = t_out_item'{LEVEL_1, LEVEL_5, 1'b0, 1'b0, 12'd2000, 1'b1};

    typedef struct {
        t_in_item  stim;
        bit        known;
        t_out_item want;
    } t_probe_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    blg_in_if  reading_if ();
    blg_out_if gauge_if ();
    blg_cfg_if target_if ();

    battery_level_gauge DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (reading_if),
        .o_out   (gauge_if),
        .i_cfg   (target_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_targets               step_tg;
    logic [SUM_BITS-1:0]    win_sum;
    logic [SAMPLE_BITS-1:0] win_max;
    logic [SAMPLE_BITS-1:0] win_min;
    logic [COUNT_BITS-1:0]  win_count;
    logic [SAMPLE_BITS-1:0] avg_q;
    logic [SUPPLY_BITS-1:0] on_ticks;
    logic [SUPPLY_BITS-1:0] off_ticks;
    logic [FULL_BITS-1:0]   full_ticks;
    logic [FULL_BITS-1:0]   not_full_ticks;
    logic                   charging;
    logic                   full_q;
    t_level                 shown_q;
    t_level                 raw_q;
    logic [TARGET_BITS-1:0] rise_ticks;
    logic [TARGET_BITS-1:0] drop_ticks;

    t_out_item    pending_readouts[$];
    t_probe_row   probe_rows[$];
    int           mismatches;
    int           quiet_cycles;
    int           random_sent;
    bit           no_idle;

    task automatic reset_gauge();
        step_tg        = t_targets'{STARTUP_TARGET_RST, TEST_TARGET_RST,
                                    NORMAL_UP_TARGET_RST, NORMAL_DOWN_TARGET_RST};
        win_sum        = '0;
        win_max        = '0;
        win_min        = '1;
        win_count      = '0;
        avg_q          = '0;
        on_ticks       = '0;
        off_ticks      = '0;
        full_ticks     = '0;
        not_full_ticks = '0;
        charging       = 1'b0;
        full_q         = 1'b0;
        shown_q        = LEVEL_1;
        raw_q          = LEVEL_3;
        rise_ticks     = '0;
        drop_ticks     = '0;
    endtask

    function automatic t_level level_for(input logic [SAMPLE_BITS-1:0] avg);
        if (charging) begin
            if (full_q) return LEVEL_5;
            if (avg >= CHG_TH4) return LEVEL_4;
            if (avg >= CHG_TH3) return LEVEL_3;
            if (avg >= CHG_TH2) return LEVEL_2;
            return LEVEL_1;
        end
        if (avg >= DIS_TH5) return LEVEL_5;
        if (avg >= DIS_TH4) return LEVEL_4;
        if (avg >= DIS_TH3) return LEVEL_3;
        if (avg >= DIS_TH2) return LEVEL_2;
        return LEVEL_1;
    endfunction

    task automatic next_readout(input t_in_item it, output t_out_item res);
        logic [TARGET_BITS-1:0] up_t;
        logic [TARGET_BITS-1:0] down_t;
        logic                   fresh;
        fresh = 1'b0;
        if (it.tick) begin
            on_ticks       = on_ticks + 1'b1;
            off_ticks      = off_ticks + 1'b1;
            full_ticks     = full_ticks + 1'b1;
            not_full_ticks = not_full_ticks + 1'b1;
            rise_ticks     = rise_ticks + 1'b1;
            if (it.key_released) drop_ticks = drop_ticks + 1'b1;
        end
        case (it.phase)
            PHASE_STARTUP: begin
                up_t   = step_tg.startup;
                down_t = step_tg.startup;
            end
            PHASE_TEST: begin
                up_t   = step_tg.test;
                down_t = step_tg.test;
            end
            default: begin
                up_t   = step_tg.normal_up;
                down_t = step_tg.normal_down;
            end
        endcase

        if (it.adc_sample >= win_max) win_max = it.adc_sample;
        if (it.adc_sample <= win_min) win_min = it.adc_sample;
        win_sum   = win_sum + SUM_BITS'(it.adc_sample);
        win_count = win_count + 1'b1;
        if (win_count >= AVG_COUNT) begin
            win_sum   = win_sum - SUM_BITS'(win_max);
            win_sum   = win_sum - SUM_BITS'(win_min);
            avg_q     = SAMPLE_BITS'(win_sum >> AVG_SHIFT);
            win_max   = '0;
            win_min   = '1;
            win_sum   = '0;
            win_count = '0;
            fresh     = 1'b1;
        end

        if (!it.supply_present) on_ticks = '0;
        else off_ticks = '0;
        if (on_ticks > SUPPLY_ON_LIMIT) begin
            on_ticks       = SUPPLY_BITS'(SUPPLY_HOLD);
            charging       = 1'b1;
            not_full_ticks = '0;
        end
        if (off_ticks > SUPPLY_OFF_LIMIT) begin
            off_ticks  = SUPPLY_BITS'(SUPPLY_HOLD);
            charging   = 1'b0;
            full_ticks = '0;
        end

        raw_q = level_for(avg_q);

        if (charging && it.phase >= PHASE_NORMAL) begin
            if (raw_q > shown_q) begin
                if (rise_ticks > up_t) begin
                    rise_ticks = '0;
                    if (shown_q < LEVEL_5) shown_q = shown_q + 1'b1;
                end
            end else begin
                rise_ticks = '0;
            end
        end else begin
            if (raw_q < shown_q) begin
                if (drop_ticks > down_t) begin
                    drop_ticks = '0;
                    if (shown_q > LEVEL_1) shown_q = shown_q - 1'b1;
                end
            end else if (raw_q > shown_q) begin
                if (rise_ticks > up_t) begin
                    rise_ticks = '0;
                    if (shown_q < LEVEL_5) shown_q = shown_q + 1'b1;
                end
            end else begin
                drop_ticks = '0;
                rise_ticks = '0;
            end
        end

        if (charging) begin
            if (!it.charge_done_pin) not_full_ticks = '0;
            else full_ticks = '0;
            if (full_ticks >= FULL_TICKS) begin
                full_ticks = FULL_BITS'(FULL_TICKS);
                full_q     = 1'b1;
            end
            if (not_full_ticks >= FULL_TICKS) begin
                not_full_ticks = FULL_BITS'(FULL_TICKS);
                full_q         = 1'b0;
            end
            if (full_q && (shown_q == LEVEL_4 || shown_q == LEVEL_5)) shown_q = LEVEL_5;
        end else begin
            full_ticks     = '0;
            not_full_ticks = FULL_BITS'(FULL_TICKS);
            full_q         = 1'b0;
        end

        res.battery_level   = shown_q;
        res.raw_level       = raw_q;
        res.charger_on      = charging;
        res.charge_full     = full_q;
        res.average_voltage = avg_q;
        res.average_updated = fresh;
    endtask

    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, 16);
    endfunction

    task automatic send_reading(input t_in_item it, input bit known = 1'b0,
                                input t_out_item want = '0);
        int unsigned gap;
        t_out_item   res;
        gap = draw_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            reading_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        reading_if.valid <= 1'b1;
        reading_if.data  <= it;
        do @(posedge i_clk); while (!reading_if.ready);
        next_readout(it, res);
        pending_readouts.push_back(known ? want : res);
    endtask

    task automatic drain_readings();
        @(negedge i_clk);
        reading_if.valid <= 1'b0;
        while (pending_readouts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_target(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [TARGET_BITS-1:0] val);
        @(negedge i_clk);
        target_if.valid <= 1'b1;
        target_if.index <= idx;
        target_if.data  <= val;
        do @(posedge i_clk); while (!target_if.ready);
        case (idx)
            CFG_STARTUP_TARGET:     step_tg.startup     = val;
            CFG_TEST_TARGET:        step_tg.test        = val;
            CFG_NORMAL_UP_TARGET:   step_tg.normal_up   = val;
            CFG_NORMAL_DOWN_TARGET: step_tg.normal_down = val;
            default: ;
        endcase
    endtask

    task automatic apply_targets(input t_targets t);
        drain_readings();
        write_target(CFG_STARTUP_TARGET, t.startup);
        write_target(CFG_TEST_TARGET, t.test);
        write_target(CFG_NORMAL_UP_TARGET, t.normal_up);
        write_target(CFG_NORMAL_DOWN_TARGET, t.normal_down);
        @(negedge i_clk);
        target_if.valid <= 1'b0;
    endtask

    function automatic logic [TARGET_BITS-1:0] pick_target();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 5) return TARGET_BITS'($urandom_range(0, 3));
        return TARGET_BITS'($urandom_range(4, 40));
    endfunction

    function automatic int pick_center();
        case ($urandom_range(0, 11))
            0:       return 1700;
            1:       return 1765;
            2:       return 1800;
            3:       return 1845;
            4:       return 1855;
            5:       return 1880;
            6:       return 1905;
            7:       return 1925;
            8:       return 1955;
            9:       return 1963;
            10:      return 1972;
            default: return 2050;
        endcase
    endfunction

    function automatic t_probe_row probe(input logic tk, input int adc, input logic sup,
                                         input logic dn, input logic key, input logic [1:0] ph,
                                         input bit known = 1'b0, input t_out_item want = '0);
        t_probe_row r;
        r.stim  = t_in_item'{tk, SAMPLE_BITS'(adc), sup, dn, key, ph};
        r.known = known;
        r.want  = want;
        return r;
    endfunction

    task automatic run_stretch();
        int         kind;
        int         len;
        int         tick_rate;
        int         done_mode;
        int         center;
        int         v;
        logic [1:0] ph;
        t_in_item   it;
        kind      = $urandom_range(0, 19);
        done_mode = $urandom_range(0, 2);
        center    = pick_center();
        no_idle   = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 5))
            0:       ph = PHASE_STARTUP;
            1:       ph = PHASE_TEST;
            5:       ph = PHASE_NORMAL_ALT;
            default: ph = PHASE_NORMAL;
        endcase
        if (kind < 8) begin
            len       = $urandom_range(60, 260);
            tick_rate = $urandom_range(8, 10);
        end else if (kind < 15) begin
            len       = $urandom_range(20, 80);
            tick_rate = $urandom_range(6, 10);
        end else begin
            len       = $urandom_range(8, 30);
            tick_rate = 5;
        end
        if (len > RANDOM_ITEMS - random_sent) len = RANDOM_ITEMS - random_sent;
        repeat (len) begin
            if ($urandom_range(0, 24) == 0) center = pick_center();
            if ($urandom_range(0, 19) == 0) v = $urandom_range(0, 4095);
            else v = center + $urandom_range(0, 40) - 20;
            it.tick       = ($urandom_range(1, 10) <= tick_rate);
            it.adc_sample = SAMPLE_BITS'(v);
            if (kind < 8) it.supply_present = ($urandom_range(0, 49) != 0);
            else if (kind < 15) it.supply_present = ($urandom_range(0, 49) == 0);
            else it.supply_present = $urandom_range(0, 1);
            if (done_mode == 0) it.charge_done_pin = 1'b0;
            else if (done_mode == 1) it.charge_done_pin = 1'b1;
            else it.charge_done_pin = $urandom_range(0, 1);
            it.key_released = ($urandom_range(0, 3) != 0);
            it.phase        = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(0, 3)) : ph;
            send_reading(it);
            random_sent++;
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (gauge_if.valid && gauge_if.ready) begin
                if (pending_readouts.size() == 0) begin
                    report_mismatch("readout with none pending", 1, 0);
                end else begin
                    want = pending_readouts.pop_front();
                    if (gauge_if.data.battery_level !== want.battery_level)
                        report_mismatch("battery_level", int'(gauge_if.data.battery_level),
                                        int'(want.battery_level));
                    if (gauge_if.data.raw_level !== want.raw_level)
                        report_mismatch("raw_level", int'(gauge_if.data.raw_level),
                                        int'(want.raw_level));
                    if (gauge_if.data.charger_on !== want.charger_on)
                        report_mismatch("charger_on", int'(gauge_if.data.charger_on),
                                        int'(want.charger_on));
                    if (gauge_if.data.charge_full !== want.charge_full)
                        report_mismatch("charge_full", int'(gauge_if.data.charge_full),
                                        int'(want.charge_full));
                    if (gauge_if.data.average_voltage !== want.average_voltage)
                        report_mismatch("average_voltage", int'(gauge_if.data.average_voltage),
                                        int'(want.average_voltage));
                    if (gauge_if.data.average_updated !== want.average_updated)
                        report_mismatch("average_updated", int'(gauge_if.data.average_updated),
                                        int'(want.average_updated));
                end
            end
            if ((reading_if.valid && reading_if.ready) || (gauge_if.valid && gauge_if.ready) ||
                (target_if.valid && target_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        int unsigned stall;
        gauge_if.ready = 1'b0;
        while (i_rst_n !== 1'b1) @(negedge i_clk);
        forever begin
            stall = draw_gap();
            @(negedge i_clk);
            if (stall != 0) begin
                gauge_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            gauge_if.ready <= 1'b1;
            do @(posedge i_clk); while (!gauge_if.valid);
        end
    end

    initial begin
        t_targets t;
        reading_if.valid = 1'b0;
        reading_if.data  = '0;
        target_if.valid  = 1'b0;
        target_if.index  = '0;
        target_if.data   = '0;
        mismatches       = 0;
        quiet_cycles     = 0;
        random_sent      = 0;
        no_idle          = 1'b0;
        reset_gauge();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        probe_rows = '{
            probe(1'b0, 0,    1'b0, 1'b1, 1'b1, PHASE_STARTUP,    1'b1, AT_REST),
            probe(1'b1, 4095, 1'b0, 1'b0, 1'b0, PHASE_TEST,       1'b1, AT_REST),
            probe(1'b0, 2000, 1'b0, 1'b1, 1'b1, PHASE_NORMAL_ALT, 1'b1, AT_REST),
            probe(1'b1, 2000, 1'b0, 1'b0, 1'b1, PHASE_NORMAL,     1'b1, AT_REST),
            probe(1'b1, 2000, 1'b0, 1'b1, 1'b0, PHASE_STARTUP,    1'b1, AT_REST),
            probe(1'b0, 2000, 1'b0, 1'b1, 1'b1, PHASE_TEST,       1'b1, AT_REST),
            probe(1'b1, 2000, 1'b0, 1'b0, 1'b1, PHASE_NORMAL,     1'b1, AT_REST),
            probe(1'b1, 2000, 1'b0, 1'b1, 1'b1, PHASE_NORMAL_ALT, 1'b1, AT_REST),
            probe(1'b0, 2000, 1'b0, 1'b1, 1'b0, PHASE_STARTUP,    1'b1, AT_REST),
            probe(1'b1, 2000, 1'b0, 1'b1, 1'b1, PHASE_STARTUP,    1'b1, FIRST_AVG),
            probe(1'b1, 1905, 1'b0, 1'b1, 1'b1, PHASE_STARTUP),
            probe(1'b1, 1850, 1'b0, 1'b1, 1'b1, PHASE_STARTUP),
            probe(1'b1, 1970, 1'b0, 1'b1, 1'b1, PHASE_STARTUP),
            probe(1'b0, 1850, 1'b0, 1'b1, 1'b0, PHASE_TEST),
            probe(1'b1, 1960, 1'b1, 1'b0, 1'b1, PHASE_NORMAL),
            probe(1'b1, 1900, 1'b1, 1'b0, 1'b0, PHASE_NORMAL_ALT),
            probe(1'b1, 1840, 1'b1, 1'b0, 1'b1, PHASE_NORMAL),
            probe(1'b1, 1968, 1'b1, 1'b0, 1'b1, PHASE_NORMAL),
            probe(1'b1, 1920, 1'b1, 1'b0, 1'b1, PHASE_NORMAL_ALT),
            probe(1'b1, 1760, 1'b1, 1'b0, 1'b0, PHASE_NORMAL),
            probe(1'b1, 4095, 1'b1, 1'b0, 1'b1, PHASE_NORMAL),
            probe(1'b1, 0,    1'b1, 1'b0, 1'b1, PHASE_NORMAL),
            probe(1'b1, 1959, 1'b1, 1'b0, 1'b1, PHASE_NORMAL_ALT),
            probe(1'b1, 1839, 1'b1, 1'b0, 1'b1, PHASE_NORMAL),
            probe(1'b1, 1967, 1'b1, 1'b0, 1'b1, PHASE_NORMAL)
        };
        foreach (probe_rows[i])
            send_reading(probe_rows[i].stim, probe_rows[i].known, probe_rows[i].want);

        apply_targets(t_targets'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        run_stretch();
        apply_targets('0);
        run_stretch();
        while (random_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) == 0) begin
                t.startup     = pick_target();
                t.test        = pick_target();
                t.normal_up   = pick_target();
                t.normal_down = pick_target();
                apply_targets(t);
            end
            run_stretch();
        end

        drain_readings();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
